// ===== sv/btree_minimum_separator_top_defines.svh =====
// Assertion macros for the btree minimum separator block.
// Used by btree_minimum_separator_top; relies on clk and rst_n in scope.
`ifndef BTREE_MINIMUM_SEPARATOR_TOP_DEFINES_SVH
`define BTREE_MINIMUM_SEPARATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BMSEP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BMSEP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BMSEP_ASSERT_IMP(lbl, ante, cons, msg)
`define BMSEP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/bmsep_pkg.sv =====
// Shared types and constants for the btree minimum separator block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bmsep_pkg;

  localparam int MAX_KEY_BYTES = 64;
  localparam int CMDQ_DEPTH    = 2;
  localparam int SEP_LEN_W     = 7;

  // One classified input word on its way from front to back.
  typedef struct packed {
    logic       is_right;
    logic       restart;
    logic       key_end;
    logic       key_empty;
    logic [7:0] key_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0]           sep_byte;
    logic                 sep_last;
    logic [SEP_LEN_W-1:0] sep_length;
    logic                 sep_empty;
    logic                 used_left;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_CMP,
    BK_EMIT_RD,
    BK_EMIT_WR
  } back_state_t;

endpackage

`default_nettype wire

// ===== sv/bmsep_front.sv =====
// Front end: accepts input words, tracks left key completion, classifies.
// Depends on bmsep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmsep_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic            in_kind,
  input  wire logic [7:0]      in_key_byte,
  input  wire logic            in_key_last,
  input  wire logic            in_key_empty,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output bmsep_pkg::cmd_t      push_cmd
);

  logic left_done_r;
  logic left_done_nxt;
  logic accept;
  logic key_end;

  assign in_tready  = push_ready;
  assign accept     = in_tvalid & push_ready;
  assign push_valid = in_tvalid;
  assign key_end    = in_key_last | in_key_empty;

  always_comb begin
    push_cmd.is_right  = in_kind;
    // a left word after a finished left key drops the pending pair
    push_cmd.restart   = ~in_kind & left_done_r;
    push_cmd.key_end   = key_end;
    push_cmd.key_empty = in_key_empty;
    push_cmd.key_byte  = in_key_byte;
  end

  always_comb begin
    left_done_nxt = left_done_r;
    if (accept) begin
      if (in_kind) begin
        // end of right key emits a separator and starts over
        left_done_nxt = ~key_end;
      end else begin
        left_done_nxt = key_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_done_r <= 1'b0;
    end else begin
      left_done_r <= left_done_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bmsep_cmdq.sv =====
// Short command queue between front and back ends.
// Depends on bmsep_pkg (cmd_t, CMDQ_DEPTH).
`timescale 1ns / 1ps
`default_nettype none

module bmsep_cmdq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire bmsep_pkg::cmd_t push_cmd,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output bmsep_pkg::cmd_t      pop_cmd
);

  localparam int DEPTH = bmsep_pkg::CMDQ_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bmsep_pkg::cmd_t  slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bmsep_back.sv =====
// Back end: key stores, prefix scan, separator choice and byte emission.
// Depends on bmsep_pkg (cmd_t, res_t, back_state_t).
`timescale 1ns / 1ps
`default_nettype none

module bmsep_back #(
  parameter int MAX_KEY_BYTES = bmsep_pkg::MAX_KEY_BYTES
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire bmsep_pkg::cmd_t cmd,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output bmsep_pkg::res_t      out_res
);

  localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);
  localparam int ADDR_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  logic [7:0] left_mem  [MAX_KEY_BYTES];
  logic [7:0] right_mem [MAX_KEY_BYTES];

  bmsep_pkg::back_state_t state_r, state_nxt;
  logic [CNT_W-1:0]  lc_r, lc_nxt;
  logic [CNT_W-1:0]  rc_r, rc_nxt;
  logic [CNT_W-1:0]  p_r, p_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              use_left_r, use_left_nxt;
  logic              out_valid_r, out_valid_nxt;
  bmsep_pkg::res_t   out_res_r, out_res_nxt;

  logic              l_we, r_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        l_rd_r, r_rd_r;

  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  sep_len;
  logic [CNT_W-1:0]  left_base;
  logic              out_free;
  logic              idx_last;

  assign lim       = (lc_r < rc_r) ? lc_r : rc_r;
  assign sep_len   = use_left_r ? lc_r : p_r + CNT_W'(1);
  assign left_base = cmd.restart ? '0 : lc_r;
  assign out_free  = ~out_valid_r | out_ready;
  assign idx_last  = ((idx_r + CNT_W'(1)) == sep_len);

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmsep_pkg::BK_IDLE: begin
        if (cmd_valid && cmd.is_right && cmd.key_end) begin
          state_nxt = bmsep_pkg::BK_SCAN;
        end
      end
      bmsep_pkg::BK_SCAN: begin
        state_nxt = (p_r == lim) ? bmsep_pkg::BK_EMIT_RD : bmsep_pkg::BK_CMP;
      end
      bmsep_pkg::BK_CMP: begin
        state_nxt = (l_rd_r == r_rd_r) ? bmsep_pkg::BK_SCAN : bmsep_pkg::BK_EMIT_RD;
      end
      bmsep_pkg::BK_EMIT_RD: begin
        state_nxt = bmsep_pkg::BK_EMIT_WR;
      end
      bmsep_pkg::BK_EMIT_WR: begin
        if (out_free) begin
          if (sep_len == '0 || idx_last) begin
            state_nxt = bmsep_pkg::BK_IDLE;
          end else begin
            state_nxt = bmsep_pkg::BK_EMIT_RD;
          end
        end
      end
      default: state_nxt = bmsep_pkg::BK_IDLE;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    cmd_ready     = 1'b0;
    l_we          = 1'b0;
    r_we          = 1'b0;
    wr_addr       = '0;
    wr_data       = cmd.key_byte;
    rd_en         = 1'b0;
    rd_addr       = p_r[ADDR_W-1:0];
    lc_nxt        = lc_r;
    rc_nxt        = rc_r;
    p_nxt         = p_r;
    idx_nxt       = idx_r;
    use_left_nxt  = use_left_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      bmsep_pkg::BK_IDLE: begin
        cmd_ready = 1'b1;
        p_nxt     = '0;
        idx_nxt   = '0;
        if (cmd_valid) begin
          if (cmd.is_right) begin
            wr_addr = rc_r[ADDR_W-1:0];
            if (cmd.key_empty) begin
              rc_nxt = '0;
            end else if (rc_r < CNT_W'(MAX_KEY_BYTES)) begin
              r_we   = 1'b1;
              rc_nxt = rc_r + CNT_W'(1);
            end
          end else begin
            wr_addr = left_base[ADDR_W-1:0];
            if (cmd.restart) begin
              rc_nxt = '0;
            end
            if (cmd.key_empty) begin
              lc_nxt = '0;
            end else if (left_base < CNT_W'(MAX_KEY_BYTES)) begin
              l_we   = 1'b1;
              lc_nxt = left_base + CNT_W'(1);
            end else begin
              lc_nxt = left_base;
            end
          end
        end
      end
      bmsep_pkg::BK_SCAN: begin
        if (p_r == lim) begin
          // one key is a prefix of the other: right wins only if longer
          use_left_nxt = (rc_r <= lc_r);
        end else begin
          rd_en = 1'b1;
        end
      end
      bmsep_pkg::BK_CMP: begin
        if (l_rd_r == r_rd_r) begin
          p_nxt = p_r + CNT_W'(1);
        end else begin
          use_left_nxt = (r_rd_r < l_rd_r);
        end
      end
      bmsep_pkg::BK_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r[ADDR_W-1:0];
      end
      bmsep_pkg::BK_EMIT_WR: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_res_nxt.used_left  = use_left_r;
          out_res_nxt.sep_length = bmsep_pkg::SEP_LEN_W'(sep_len);
          if (sep_len == '0) begin
            out_res_nxt.sep_byte  = '0;
            out_res_nxt.sep_last  = 1'b1;
            out_res_nxt.sep_empty = 1'b1;
          end else begin
            out_res_nxt.sep_byte  = use_left_r ? l_rd_r : r_rd_r;
            out_res_nxt.sep_last  = idx_last;
            out_res_nxt.sep_empty = 1'b0;
          end
          if (sep_len == '0 || idx_last) begin
            lc_nxt = '0;
            rc_nxt = '0;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r & ~out_ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      left_mem[wr_addr] <= wr_data;
    end
    if (r_we) begin
      right_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      l_rd_r <= left_mem[rd_addr];
      r_rd_r <= right_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    idx_r      <= idx_nxt;
    use_left_r <= use_left_nxt;
    out_res_r  <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmsep_pkg::BK_IDLE;
      lc_r        <= '0;
      rc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lc_r        <= lc_nxt;
      rc_r        <= rc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/btree_minimum_separator_top.sv =====
// Shortest separator between a left and a right B-tree key.
//
// Input stream: one word per key byte. in_tuser selects the key (0 left,
// 1 right), in_tlast ends the key, in_tdata carries the byte and an
// empty-key flag. When the right key ends, the block emits the separator
// on the output stream one byte per word, out_tlast on the final word; an
// empty separator is a single word with the empty flag set.
// Throughput: a front end classifies words into a two-entry command queue,
// so input words are taken one per cycle while the queue has room. The back
// end loads one byte per cycle while idle; at the end of a right key it
// scans the keys, each byte by a registered key store read (SCAN) and
// then a compare (CMP), then emits each separator byte by a key store
// read (EMIT_RD) and an output register write (EMIT_WR), and takes no new
// command until the last separator byte is in the output register.
// Reset clears the queue, the key lengths and the output valid flag; the key
// stores are not cleared. A stalled receiver holds the output word; the
// back end waits and the queue fills, after which in_tready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "btree_minimum_separator_top_defines.svh"

module btree_minimum_separator_top #(
  parameter int MAX_KEY_BYTES = bmsep_pkg::MAX_KEY_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] key_byte, [8] key_empty, [15:9] zero
  input  wire logic        in_tlast,   // key_last
  input  wire logic [0:0]  in_tuser,   // [0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] sep_byte, [14:8] sep_length, [15] sep_empty
  output logic             out_tlast,  // sep_last
  output logic [0:0]       out_tuser   // [0] used_left
);

  logic            push_valid;
  logic            push_ready;
  bmsep_pkg::cmd_t push_cmd;
  logic            cmd_valid;
  logic            cmd_ready;
  bmsep_pkg::cmd_t cmd;
  bmsep_pkg::res_t res;

  bmsep_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_kind      (in_tuser[0]),
    .in_key_byte  (in_tdata[7:0]),
    .in_key_last  (in_tlast),
    .in_key_empty (in_tdata[8]),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_cmd     (push_cmd)
  );

  bmsep_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (cmd_valid),
    .pop_ready  (cmd_ready),
    .pop_cmd    (cmd)
  );

  bmsep_back #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {res.sep_empty, res.sep_length, res.sep_byte};
  assign out_tlast = res.sep_last;
  assign out_tuser = res.used_left;

  `BMSEP_ASSERT_IMP(a_empty_word_shape, out_tvalid && res.sep_empty,
    res.sep_last && (res.sep_length == '0), "empty separator word malformed")
  `BMSEP_ASSERT_IMP(a_right_never_empty, out_tvalid && !res.used_left,
    !res.sep_empty && (res.sep_length != '0), "right-key separator is empty")
  `BMSEP_ASSERT_IMP(a_stall_means_queued, !in_tready, cmd_valid,
    "input stalled with empty command queue")

endmodule

`default_nettype wire
